@@ src/alarm_controller_entry_exit_delay_core_macros.svh @@
// Assertion macros for the alarm controller entry/exit delay core.
// Used by the port checker; needs i_clk and i_rst_n in the enclosing scope.
`ifndef ALARM_CONTROLLER_ENTRY_EXIT_DELAY_CORE_MACROS_SVH
`define ALARM_CONTROLLER_ENTRY_EXIT_DELAY_CORE_MACROS_SVH

// Check a property outside reset.
`define AEED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define AEED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/aeed_pkg.sv @@
// Shared types, constants and helpers for the alarm controller core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aeed_pkg;

    localparam int DelayW    = 10;
    localparam int BlinkW    = 4;
    localparam int CfgAddrW  = 2;
    localparam int CfgDataW  = 10;
    localparam int ModeCodeW = 3;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 8;

    // Register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] CFG_DELAY_TICKS = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_FAST_BLINK  = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_SLOW_BLINK  = 2'd2;

    localparam logic [DelayW-1:0] RST_DELAY_TICKS = 10'd100;
    localparam logic [BlinkW-1:0] RST_FAST_BLINK  = 4'd2;
    localparam logic [BlinkW-1:0] RST_SLOW_BLINK  = 4'd5;

    // Mode codes as seen on the result beat
    localparam logic [ModeCodeW-1:0] CODE_IDLE  = 3'd0;
    localparam logic [ModeCodeW-1:0] CODE_EXIT  = 3'd1;
    localparam logic [ModeCodeW-1:0] CODE_ARMED = 3'd2;
    localparam logic [ModeCodeW-1:0] CODE_ENTRY = 3'd3;
    localparam logic [ModeCodeW-1:0] CODE_ALARM = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_EXIT  = 5'b00010,
        MODE_ARMED = 5'b00100,
        MODE_ENTRY = 5'b01000,
        MODE_ALARM = 5'b10000
    } t_mode;

    typedef enum logic [3:0] {
        DISP_OFF  = 4'b0001,
        DISP_ON   = 4'b0010,
        DISP_SLOW = 4'b0100,
        DISP_FAST = 4'b1000
    } t_disp;

    typedef struct packed {
        t_mode mode;
        t_disp disp;
        logic  siren;
    } t_ctl;

    function automatic logic [ModeCodeW-1:0] mode_code(input t_mode m);
        logic [ModeCodeW-1:0] c;
        case (m)
            MODE_EXIT:  c = CODE_EXIT;
            MODE_ARMED: c = CODE_ARMED;
            MODE_ENTRY: c = CODE_ENTRY;
            MODE_ALARM: c = CODE_ALARM;
            default:    c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/aeed_mode.sv @@
// Mode machine: button edge detect, exit/entry delay counter and siren.
// Depends on aeed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeed_mode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic                         i_door,
    input  wire logic                         i_button,
    input  wire logic [aeed_pkg::DelayW-1:0]  i_delay_ticks,
    output aeed_pkg::t_ctl                    o_ctl_next
);
    import aeed_pkg::*;

    t_mode             r_mode, n_mode;
    t_disp             r_disp, n_disp;
    logic              r_siren, n_siren;
    logic              r_button_prev;
    logic [DelayW-1:0] r_delay_count, n_delay_count;
    logic              press;
    logic              expired;

    always_comb begin
        press         = i_button & ~r_button_prev;
        expired       = (r_delay_count >= i_delay_ticks);
        n_mode        = r_mode;
        n_disp        = r_disp;
        n_siren       = r_siren;
        n_delay_count = r_delay_count;
        case (r_mode)
            MODE_IDLE: begin
                if (press && !i_door) begin
                    n_delay_count = '0;
                    n_disp        = DISP_SLOW;
                    n_mode        = MODE_EXIT;
                end
            end
            MODE_EXIT: begin
                // press beats expiry here
                if (press) begin
                    n_disp = DISP_OFF;
                    n_mode = MODE_IDLE;
                end else if (expired) begin
                    n_disp = DISP_ON;
                    n_mode = MODE_ARMED;
                end else begin
                    n_delay_count = DelayW'(r_delay_count + 1'b1);
                end
            end
            MODE_ARMED: begin
                if (i_door) begin
                    n_delay_count = '0;
                    n_disp        = DISP_FAST;
                    n_mode        = MODE_ENTRY;
                end
            end
            MODE_ENTRY: begin
                // expiry beats press here
                if (expired) begin
                    n_siren = 1'b1;
                    n_mode  = MODE_ALARM;
                end else if (press) begin
                    n_disp = DISP_OFF;
                    n_mode = MODE_IDLE;
                end else begin
                    n_delay_count = DelayW'(r_delay_count + 1'b1);
                end
            end
            MODE_ALARM: begin
                if (press) begin
                    n_siren = 1'b0;
                    n_disp  = DISP_OFF;
                    n_mode  = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_disp        <= DISP_OFF;
            r_siren       <= 1'b0;
            r_button_prev <= 1'b0;
            r_delay_count <= '0;
        end else if (i_adv) begin
            r_mode        <= n_mode;
            r_disp        <= n_disp;
            r_siren       <= n_siren;
            r_button_prev <= i_button;
            r_delay_count <= n_delay_count;
        end
    end

    assign o_ctl_next = '{mode: n_mode, disp: n_disp, siren: n_siren};

endmodule

`default_nettype wire

@@ src/aeed_led.sv @@
// Status LED driver: off, on, or toggling at the fast or slow blink period.
// Depends on aeed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeed_led (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire aeed_pkg::t_disp              i_disp,
    input  wire logic [aeed_pkg::BlinkW-1:0]  i_fast_ticks,
    input  wire logic [aeed_pkg::BlinkW-1:0]  i_slow_ticks,
    output logic                              o_led_next
);
    import aeed_pkg::*;

    logic [BlinkW-1:0] r_blink_count, n_blink_count;
    logic              r_led, n_led;
    logic [BlinkW-1:0] count_inc;
    logic [BlinkW-1:0] period;

    always_comb begin
        count_inc     = BlinkW'(r_blink_count + 1'b1);
        period        = (i_disp == DISP_FAST) ? i_fast_ticks : i_slow_ticks;
        n_blink_count = '0;
        n_led         = 1'b0;
        case (i_disp)
            DISP_FAST, DISP_SLOW: begin
                if (count_inc >= period) begin
                    n_blink_count = '0;
                    n_led         = ~r_led;
                end else begin
                    n_blink_count = count_inc;
                    n_led         = r_led;
                end
            end
            DISP_ON: begin
                n_led = 1'b1;
            end
            default: begin
                n_led = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_count <= '0;
            r_led         <= 1'b0;
        end else if (i_adv) begin
            r_blink_count <= n_blink_count;
            r_led         <= n_led;
        end
    end

    assign o_led_next = n_led;

endmodule

`default_nettype wire

@@ src/alarm_controller_entry_exit_delay_core.sv @@
// Intruder alarm controller with entry and exit delay: top level.
// Depends on aeed_pkg, aeed_mode and aeed_led.
// Stages: input register, mode/LED logic, result register. A tick waits in the
// input register until the result slot is free; one tick per cycle unless stalled.
// Reset (synchronous, i_rst_n low): idle mode, LED and siren off, both sides empty,
// delay 100 ticks, fast blink 2 ticks, slow blink 5 ticks.
`timescale 1ns / 1ps
`default_nettype none

module alarm_controller_entry_exit_delay_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [aeed_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  wire logic [aeed_pkg::CfgDataW-1:0]  i_cfg_wdata,
    // tick input
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] door_active, [1] button_level, [7:2] zero
    input  wire logic [aeed_pkg::InDataW-1:0]   i_s_axis_tdata,
    // result output
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [0] status_led, [1] siren_on, [4:2] mode_code, [7:5] zero
    output logic [aeed_pkg::OutDataW-1:0]       o_m_axis_tdata
);
    import aeed_pkg::*;

    // Configuration registers
    logic [DelayW-1:0] r_delay_ticks;
    logic [BlinkW-1:0] r_fast_ticks;
    logic [BlinkW-1:0] r_slow_ticks;

    // Input stage
    logic r_in_valid;
    logic r_in_door;
    logic r_in_button;

    // Result stage
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic [OutDataW-1:0] n_out_data;

    logic adv;
    logic in_fire;
    t_ctl ctl_next;
    logic led_next;

    // Move the held tick into the result register whenever that slot frees up;
    // the mode and LED state advance on the same edge.
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= RST_DELAY_TICKS;
            r_fast_ticks  <= RST_FAST_BLINK;
            r_slow_ticks  <= RST_SLOW_BLINK;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DELAY_TICKS: r_delay_ticks <= i_cfg_wdata[DelayW-1:0];
                CFG_FAST_BLINK:  r_fast_ticks  <= i_cfg_wdata[BlinkW-1:0];
                CFG_SLOW_BLINK:  r_slow_ticks  <= i_cfg_wdata[BlinkW-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Input register: hold the beat until it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_door   <= i_s_axis_tdata[0];
            r_in_button <= i_s_axis_tdata[1];
        end
    end

    aeed_mode u_mode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_door        (r_in_door),
        .i_button      (r_in_button),
        .i_delay_ticks (r_delay_ticks),
        .o_ctl_next    (ctl_next)
    );

    // LED follows the display choice made after this tick's mode update
    aeed_led u_led (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_disp       (ctl_next.disp),
        .i_fast_ticks (r_fast_ticks),
        .i_slow_ticks (r_slow_ticks),
        .o_led_next   (led_next)
    );

    assign n_out_data = {{(OutDataW - ModeCodeW - 2){1'b0}},
                         mode_code(ctl_next.mode), ctl_next.siren, led_next};

    // Result register: load on advance, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ src/aeed_chk.sv @@
// Port-level checker for the alarm controller core, bound to the top level.
// Depends on aeed_pkg and alarm_controller_entry_exit_delay_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "alarm_controller_entry_exit_delay_core_macros.svh"

module aeed_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [aeed_pkg::OutDataW-1:0] i_m_tdata
);
    import aeed_pkg::*;

    `AEED_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_m_tvalid, "result beat right after reset")
    `AEED_ASSERT(a_stall_hold, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "stalled result beat changed")
    `AEED_ASSERT(a_siren_alarm, i_m_tvalid |-> (i_m_tdata[1] == (i_m_tdata[4:2] == CODE_ALARM)), "siren does not match alarm mode")
    `AEED_ASSERT(a_led_mode, i_m_tvalid && (i_m_tdata[4:2] == CODE_IDLE || i_m_tdata[4:2] == CODE_ARMED) |-> (i_m_tdata[0] == (i_m_tdata[4:2] == CODE_ARMED)), "LED wrong for idle or armed")

endmodule

bind alarm_controller_entry_exit_delay_core aeed_chk u_aeed_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
